// ===== design/pdt_pkg.sv =====
// Shared types and codes for the periodic task dispatch table.
`timescale 1ns / 1ps
`default_nettype none
package pdt_pkg;

  localparam int MAX_TASKS_DEF = 32;
  localparam int NUM_LISTS_DEF = 3;

  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_REG  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EXISTS = 2'd2
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [1:0]  list_select;
    logic [15:0] task_key;
    logic [31:0] task_period;
    logic [31:0] now_us;
  } dispatch_in_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  due_slot;
    logic [15:0] due_key;
    logic        is_due;
    logic        last_of_run;
  } dispatch_out_t;

endpackage
`default_nettype wire

// ===== design/pdt_front.sv =====
// Front stage: accepts input beats and drops those that name a missing list.
`timescale 1ns / 1ps
`default_nettype none
module pdt_front import pdt_pkg::*; #(
  parameter int NUM_LISTS = NUM_LISTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire dispatch_in_t in_data,
  output logic              f_valid,
  input  wire logic         f_ready,
  output dispatch_in_t      f_data
);

  logic         f_vld_r, f_vld_nxt;
  dispatch_in_t f_data_r, f_data_nxt;
  logic         list_ok;

  assign in_ready = !f_vld_r || f_ready;
  assign list_ok  = int'(in_data.list_select) < NUM_LISTS;
  assign f_valid  = f_vld_r;
  assign f_data   = f_data_r;

  always_comb begin
    f_vld_nxt  = f_vld_r && !f_ready;
    f_data_nxt = f_data_r;
    if (in_valid && in_ready && list_ok) begin
      f_vld_nxt  = 1'b1;
      f_data_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_data_r <= f_data_nxt;
  end

endmodule
`default_nettype wire

// ===== design/pdt_queue.sv =====
// Two-entry queue between the front stage and the dispatch engine.
`timescale 1ns / 1ps
`default_nettype none
module pdt_queue import pdt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire dispatch_in_t push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output dispatch_in_t      pop_data
);

  dispatch_in_t slot_mem [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   fill_r, fill_nxt;
  logic         do_push, do_pop;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign pop_data   = slot_mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/pdt_back.sv =====
// Dispatch engine: walks one task list per item and holds the entry memories.
`timescale 1ns / 1ps
`default_nettype none
module pdt_back import pdt_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int NUM_LISTS = NUM_LISTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  output logic              q_ready,
  input  wire dispatch_in_t q_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output dispatch_out_t     out_data
);

  localparam int DEPTH = NUM_LISTS * MAX_TASKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_TASKS + 1);
  localparam int IW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_DONE = 3'b100
  } bstate_t;

  logic [15:0] key_mem  [DEPTH];
  logic [31:0] per_mem  [DEPTH];
  logic [31:0] last_mem [DEPTH];

  bstate_t       state_r, state_nxt;
  logic          op_r, op_nxt;
  logic [15:0]   key_r, key_nxt;
  logic [31:0]   period_r, period_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [LW-1:0] lidx_r, lidx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          ev_vld_r, ev_vld_nxt;
  logic [IW-1:0] ev_slot_r, ev_slot_nxt;
  logic          found_r, found_nxt;
  logic          hold_vld_r, hold_vld_nxt;
  logic [IW-1:0] hold_slot_r, hold_slot_nxt;
  logic [15:0]   hold_key_r, hold_key_nxt;
  logic          out_vld_r, out_vld_nxt;
  dispatch_out_t out_data_r, out_data_nxt;
  logic [CW-1:0] count_r [NUM_LISTS];
  logic [CW-1:0] count_nxt [NUM_LISTS];

  logic [15:0]   rd_key_r;
  logic [31:0]   rd_per_r;
  logic [31:0]   rd_last_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  logic          last_we;
  logic [AW-1:0] last_waddr;
  logic [LW-1:0] lidx_in;
  logic [31:0]   elapsed;
  logic          hit_due;
  logic          hit_key;
  logic          out_free;
  logic          advance;
  logic          scan_end;
  status_t       reg_status;
  logic          push_out;
  dispatch_out_t push_data;

  assign lidx_in  = LW'(q_data.list_select);
  assign elapsed  = now_r - rd_last_r;
  assign hit_due  = ev_vld_r && (op_r == OP_EXEC)
                    && ((rd_per_r == 32'd0) || (elapsed >= rd_per_r));
  assign hit_key  = ev_vld_r && (op_r == OP_REG) && (rd_key_r == key_r);
  assign out_free = !out_vld_r || out_ready;
  assign advance  = !(hit_due && hold_vld_r && !out_free);
  assign scan_end = iss_r == cnt_r;
  assign rd_addr  = base_r + AW'(iss_r);

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (cnt_r >= CW'(MAX_TASKS)) begin
      reg_status = ST_FULL;
    end else if (found_r) begin
      reg_status = ST_EXISTS;
    end else begin
      reg_status = ST_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    period_nxt    = period_r;
    now_nxt       = now_r;
    base_nxt      = base_r;
    lidx_nxt      = lidx_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    ev_vld_nxt    = ev_vld_r;
    ev_slot_nxt   = ev_slot_r;
    found_nxt     = found_r;
    hold_vld_nxt  = hold_vld_r;
    hold_slot_nxt = hold_slot_r;
    hold_key_nxt  = hold_key_r;
    count_nxt     = count_r;
    q_ready       = 1'b0;
    rd_en         = 1'b0;
    ent_we        = 1'b0;
    ent_waddr     = base_r + AW'(cnt_r);
    last_we       = 1'b0;
    last_waddr    = base_r + AW'(ev_slot_r);
    push_out      = 1'b0;
    push_data     = '0;

    case (state_r)
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          op_nxt       = q_data.operation;
          key_nxt      = q_data.task_key;
          period_nxt   = q_data.task_period;
          now_nxt      = q_data.now_us;
          lidx_nxt     = lidx_in;
          base_nxt     = AW'(int'(lidx_in) * MAX_TASKS);
          cnt_nxt      = count_r[lidx_in];
          iss_nxt      = '0;
          ev_vld_nxt   = 1'b0;
          found_nxt    = 1'b0;
          hold_vld_nxt = 1'b0;
          state_nxt    = B_SCAN;
        end
      end
      B_SCAN: begin
        if (advance) begin
          if (hit_key) begin
            found_nxt = 1'b1;
          end
          if (hit_due) begin
            last_we       = 1'b1;
            hold_vld_nxt  = 1'b1;
            hold_slot_nxt = ev_slot_r;
            hold_key_nxt  = rd_key_r;
            if (hold_vld_r) begin
              push_out  = 1'b1;
              push_data = '{status: ST_OK, due_slot: 5'(hold_slot_r),
                            due_key: hold_key_r, is_due: 1'b1, last_of_run: 1'b0};
            end
          end
          if (scan_end) begin
            ev_vld_nxt = 1'b0;
            state_nxt  = B_DONE;
          end else begin
            rd_en       = 1'b1;
            ev_vld_nxt  = 1'b1;
            ev_slot_nxt = IW'(iss_r);
            iss_nxt     = iss_r + CW'(1);
          end
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
          if (op_r == OP_REG) begin
            push_out  = 1'b1;
            push_data = '{status: reg_status, due_slot: 5'd0, due_key: 16'd0,
                          is_due: 1'b0, last_of_run: 1'b1};
            if (reg_status == ST_OK) begin
              ent_we             = 1'b1;
              last_we            = 1'b1;
              last_waddr         = base_r + AW'(cnt_r);
              count_nxt[lidx_r]  = cnt_r + CW'(1);
            end
          end else if (hold_vld_r) begin
            push_out  = 1'b1;
            push_data = '{status: ST_OK, due_slot: 5'(hold_slot_r),
                          due_key: hold_key_r, is_due: 1'b1, last_of_run: 1'b1};
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    if (push_out) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      ev_vld_r   <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      count_r    <= '{default: '0};
    end else begin
      state_r    <= state_nxt;
      ev_vld_r   <= ev_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    period_r    <= period_nxt;
    now_r       <= now_nxt;
    base_r      <= base_nxt;
    lidx_r      <= lidx_nxt;
    cnt_r       <= cnt_nxt;
    iss_r       <= iss_nxt;
    ev_slot_r   <= ev_slot_nxt;
    found_r     <= found_nxt;
    hold_slot_r <= hold_slot_nxt;
    hold_key_r  <= hold_key_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r  <= key_mem[rd_addr];
      rd_per_r  <= per_mem[rd_addr];
      rd_last_r <= last_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[ent_waddr] <= key_r;
      per_mem[ent_waddr] <= period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (last_we) begin
      last_mem[last_waddr] <= now_r;
    end
  end

endmodule
`default_nettype wire

// ===== design/periodic_task_dispatch_table.sv =====
// Top level of the periodic task dispatch table.
//
//   Channel   Ports                         Carries
//   input     in_valid, in_ready, in_data   one register or execute request a beat
//   output    out_valid, out_ready, out_data one status or due-task report a beat
//
// The engine walks every entry of the selected list, which holds at most MAX_TASKS
// entries, and reads one entry a cycle from the entry memories unless a stalled
// output holds it.
// Reset clears the list counts and all handshake state; entry memories are not cleared.
// A stalled output holds the engine when a due task is found while an earlier one
// still waits, and at the end of every item until the output register is free.
// The front stage and a two-entry queue keep accepting beats meanwhile until they fill.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_dispatch_table import pdt_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int NUM_LISTS = NUM_LISTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire dispatch_in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output dispatch_out_t     out_data
);

  logic         f_valid, f_ready;
  dispatch_in_t f_data;
  logic         q_valid, q_ready;
  dispatch_in_t q_data;

  pdt_front #(
    .NUM_LISTS (NUM_LISTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  pdt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  pdt_back #(
    .MAX_TASKS (MAX_TASKS),
    .NUM_LISTS (NUM_LISTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== design/pdt_checker.sv =====
// Port-level checks for the periodic task dispatch table and their binding.
`timescale 1ns / 1ps
`default_nettype none
module pdt_checker import pdt_pkg::*; (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire dispatch_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_FULL
                  || out_data.status == ST_EXISTS)
    else $error("undefined status code");

  a_reg_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_due |-> out_data.last_of_run)
    else $error("register report is not the last beat");

  a_reg_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_due |-> out_data.due_slot == 5'd0
                                      && out_data.due_key == 16'd0)
    else $error("register report carries slot or key");

  a_due_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_due |-> out_data.status == ST_OK)
    else $error("due report carries a nonzero status");

endmodule

bind periodic_task_dispatch_table pdt_checker u_pdt_checker (.*);
`default_nettype wire
